### hdl/assert_macros.svh
// Assertion helpers for the RTL. They compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked at every clock edge once reset has been released
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
// Condition that must never be seen once reset has been released
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### hdl/qaa_pkg.sv
package qaa_pkg;

	// Width of every payload field on the channels
	localparam int FIELD_W = 16;

	// Angle accumulator: degrees, 24 fraction bits, signed
	localparam int HALF_W = 34;
	localparam int DEG_Q = 24;
	localparam longint DEG_PER_RAD_Q24 = 64'sd961263669;
	localparam logic signed [HALF_W-1:0] HALF_TURN_Q24 = HALF_W'(64'sd180 <<< DEG_Q);
	localparam logic signed [HALF_W-1:0] QUARTER_TURN_Q24 = HALF_W'(64'sd90 <<< DEG_Q);

	// Angle code of a full turn (360 degrees, 7 fraction bits)
	localparam logic [FIELD_W-1:0] FULL_TURN_CODE = 16'd46080;

	// Saturation limits of the axis components
	localparam logic [FIELD_W-1:0] AXIS_POS_MAX = 16'h7fff;
	localparam logic [FIELD_W-1:0] AXIS_NEG_MAX = 16'h8000;

	// Arctangent of 2^-i in degrees, Q24
	function automatic logic signed [HALF_W-1:0] atan_deg_q24(input int unsigned i);
		logic signed [HALF_W-1:0] r;
		case (i)
			0: r = 34'sd754974720;
			1: r = 34'sd445687602;
			2: r = 34'sd235489089;
			3: r = 34'sd119537938;
			4: r = 34'sd60000934;
			5: r = 34'sd30029717;
			6: r = 34'sd15018523;
			7: r = 34'sd7509720;
			8: r = 34'sd3754917;
			9: r = 34'sd1877466;
			10: r = 34'sd938734;
			11: r = 34'sd469367;
			default: r = HALF_W'(DEG_PER_RAD_Q24 >>> i);
		endcase
		return r;
	endfunction

endpackage

### hdl/qaa_quat_if.sv
interface qaa_quat_if import qaa_pkg::*;;
	logic valid;
	logic ready;
	logic signed [FIELD_W-1:0] quat_w;
	logic signed [FIELD_W-1:0] quat_x;
	logic signed [FIELD_W-1:0] quat_y;
	logic signed [FIELD_W-1:0] quat_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

### hdl/qaa_axang_if.sv
interface qaa_axang_if import qaa_pkg::*;;
	logic valid;
	logic ready;
	logic [FIELD_W-1:0] angle_deg;
	logic signed [FIELD_W-1:0] axis_x;
	logic signed [FIELD_W-1:0] axis_y;
	logic signed [FIELD_W-1:0] axis_z;
	logic axis_valid;

	modport source (output valid, angle_deg, axis_x, axis_y, axis_z, axis_valid,
		input ready);
	modport sink (input valid, angle_deg, axis_x, axis_y, axis_z, axis_valid,
		output ready);
endinterface

### hdl/quaternion_to_axis_angle_top.sv
// Quaternion to axis-angle converter. Takes one quaternion beat per cycle while quat.ready
// is high, and returns the rotation angle 2*acos(w) in degrees (Q7, wrapped into [0,360))
// and the axis (x,y,z)/sqrt(1-w*w) saturated to 16 bits, with axis_valid low and a zero
// axis for a null rotation. The pipeline is built from a bit-per-stage square root
// (FRAC_BITS+1 stages), the CORDIC
// arctangent (CORDIC_STAGES stages) and three bit-per-stage restoring dividers
// (FRAC_BITS+16 stages). Every stage is registered; a stalled output holds only the
// stages that are full, so empty stages keep draining and input is taken meanwhile.
`include "assert_macros.svh"

module quaternion_to_axis_angle_top import qaa_pkg::*; #(
	parameter int FRAC_BITS = 14,
	parameter int CORDIC_STAGES = 16
) (
	input logic clk,
	input logic arst_n,
	qaa_quat_if.sink quat,
	qaa_axang_if.source axang
);

	localparam int F = FRAC_BITS;
	localparam int CS = CORDIC_STAGES;
	localparam int WW = (F + 2 > FIELD_W) ? F + 2 : FIELD_W;	// clamped w
	localparam int XW = WW + 1;					// w before clamping
	localparam int RADW = 2 * F + 2;				// radicand
	localparam int NR = F + 1;					// root bits / stages
	localparam int SW = F + 1;					// root width
	localparam int RW = F + 2;					// root remainder
	localparam int CW = F + 4;					// CORDIC x/y
	localparam int NW = F + 16;					// dividend / quotient
	localparam int QW = 3 * FIELD_W;
	localparam int SQC_W = WW + QW;				// w, x, y, z
	localparam int CDC_W = SW + QW + 2;			// s, x, y, z, zero, wpos
	localparam int NT = NR + CS + NW + 2;		// total stages

	// ---------------- flow control ----------------
	logic [NT-1:0] vld_s;
	logic [NT-1:0] adv;

	// a stage may load when it is empty or its content moves on
	always_comb begin
		adv[NT-1] = !vld_s[NT-1] || axang.ready;
		for (int k = NT - 2; k >= 0; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign quat.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= quat.valid;
			end
			for (int k = 1; k < NT; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// ---------------- stage 1: clamp and 1 - w^2 ----------------
	logic [RADW-1:0] sq_rad_s [0:NR];
	logic [RW-1:0] sq_rem_s [0:NR];
	logic [SW-1:0] sq_root_s [0:NR];
	logic [SQC_W-1:0] sq_c_s [0:NR];

	logic signed [XW-1:0] w_ext;
	logic signed [WW-1:0] w_cl;
	logic signed [2*WW-1:0] w_sq;

	always_comb begin
		w_ext = XW'(quat.quat_w);
		if (w_ext > (XW'(1) <<< F)) begin
			w_cl = WW'(XW'(1) <<< F);
		end else if (w_ext < -(XW'(1) <<< F)) begin
			w_cl = WW'(-(XW'(1) <<< F));
		end else begin
			w_cl = WW'(w_ext);
		end
		w_sq = w_cl * w_cl;
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			sq_rad_s[0] <= (RADW'(1) << (2 * F)) - RADW'(w_sq);
			sq_rem_s[0] <= '0;
			sq_root_s[0] <= '0;
			sq_c_s[0] <= {w_cl, quat.quat_x, quat.quat_y, quat.quat_z};
		end
	end

	// ---------------- square root, one root bit a stage ----------------
	for (genvar k = 1; k <= NR; k++) begin : g_sqrt
		logic [RW+1:0] t;
		logic [RW+1:0] trial;
		logic ge;

		assign t = {sq_rem_s[k-1], sq_rad_s[k-1][RADW-1 -: 2]};
		assign trial = (RW + 2)'({sq_root_s[k-1], 2'b01});
		assign ge = (t >= trial);

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				sq_rem_s[k] <= ge ? RW'(t - trial) : RW'(t);
				sq_root_s[k] <= {sq_root_s[k-1][SW-2:0], ge};
				sq_rad_s[k] <= sq_rad_s[k-1] << 2;
				sq_c_s[k] <= sq_c_s[k-1];
			end
		end
	end

	// ---------------- CORDIC set-up ----------------
	logic signed [WW-1:0] w_r;
	logic signed [CW-1:0] w_c;
	logic [SW-1:0] s_r;
	logic signed [CW-1:0] cx0, cy0;
	logic signed [HALF_W-1:0] h0;
	logic [CDC_W-1:0] cc0;

	always_comb begin
		w_r = sq_c_s[NR][SQC_W-1 -: WW];
		s_r = sq_root_s[NR];
		w_c = CW'(w_r);
		// start in the right half plane
		if (w_r < 0) begin
			cx0 = CW'({1'b0, s_r});
			cy0 = -w_c;
			h0 = QUARTER_TURN_Q24;
		end else begin
			cx0 = w_c;
			cy0 = CW'({1'b0, s_r});
			h0 = '0;
		end
		cc0 = {s_r, sq_c_s[NR][QW-1:0], (s_r == '0), (w_r > 0)};
	end

	// ---------------- CORDIC vectoring stages ----------------
	logic signed [CW-1:0] cd_x_s [1:CS];
	logic signed [CW-1:0] cd_y_s [1:CS];
	logic signed [HALF_W-1:0] cd_h_s [1:CS];
	logic [CDC_W-1:0] cd_c_s [1:CS];

	for (genvar i = 1; i <= CS; i++) begin : g_cordic
		logic signed [CW-1:0] px, py;
		logic signed [HALF_W-1:0] ph;
		logic [CDC_W-1:0] pc;
		logic signed [CW-1:0] dx, dy;

		if (i == 1) begin : g_first
			assign px = cx0;
			assign py = cy0;
			assign ph = h0;
			assign pc = cc0;
		end else begin : g_next
			assign px = cd_x_s[i-1];
			assign py = cd_y_s[i-1];
			assign ph = cd_h_s[i-1];
			assign pc = cd_c_s[i-1];
		end

		assign dx = py >>> (i - 1);
		assign dy = px >>> (i - 1);

		always_ff @(posedge clk) begin
			if (adv[NR+i]) begin
				if (!py[CW-1]) begin
					cd_x_s[i] <= px + dx;
					cd_y_s[i] <= py - dy;
					cd_h_s[i] <= ph + atan_deg_q24(i - 1);
				end else begin
					cd_x_s[i] <= px - dx;
					cd_y_s[i] <= py + dy;
					cd_h_s[i] <= ph - atan_deg_q24(i - 1);
				end
				cd_c_s[i] <= pc;
			end
		end
	end

	// ---------------- angle code and divider set-up ----------------
	logic [NW-1:0] dv_num_s [0:NW][0:2];
	logic [F-1:0] dv_rem_s [0:NW][0:2];
	logic [2:0] dv_neg_s [0:NW];
	logic [SW-1:0] dv_div_s [0:NW];
	logic [FIELD_W-1:0] dv_code_s [0:NW];
	logic dv_ok_s [0:NW];

	logic signed [HALF_W-1:0] h_cl;
	logic [HALF_W:0] h2;
	logic [FIELD_W-1:0] code_raw, code_w;
	logic zero_s, w_pos;
	logic [SW-1:0] s_c;

	always_comb begin
		s_c = cd_c_s[CS][CDC_W-1 -: SW];
		zero_s = cd_c_s[CS][1];
		w_pos = cd_c_s[CS][0];
		if (zero_s) begin
			h_cl = w_pos ? '0 : HALF_TURN_Q24;
		end else if (cd_h_s[CS] < 0) begin
			h_cl = '0;
		end else if (cd_h_s[CS] > HALF_TURN_Q24) begin
			h_cl = HALF_TURN_Q24;
		end else begin
			h_cl = cd_h_s[CS];
		end
		// twice the half angle, rounded half up to Q7
		h2 = (HALF_W + 1)'({h_cl[HALF_W-2:0], 1'b0}) + (HALF_W + 1)'(65536);
		code_raw = h2[32:17];
		code_w = (code_raw >= FULL_TURN_CODE) ? code_raw - FULL_TURN_CODE : code_raw;
	end

	for (genvar l = 0; l < 3; l++) begin : g_dvin
		logic signed [FIELD_W:0] e;
		logic [FIELD_W:0] mag;

		assign e = (FIELD_W + 1)'(signed'(cd_c_s[CS][2 + (2 - l) * FIELD_W +: FIELD_W]));
		assign mag = (e < 0) ? (FIELD_W + 1)'(-e) : (FIELD_W + 1)'(e);

		always_ff @(posedge clk) begin
			if (adv[NR+CS+1]) begin
				dv_num_s[0][l] <= (NW'(mag) << F) + NW'(s_c >> 1);
				dv_rem_s[0][l] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NR+CS+1]) begin
			dv_neg_s[0] <= {cd_c_s[CS][2+3*FIELD_W-1], cd_c_s[CS][2+2*FIELD_W-1],
				cd_c_s[CS][2+FIELD_W-1]};
			dv_div_s[0] <= s_c;
			dv_code_s[0] <= code_w;
			dv_ok_s[0] <= (code_w != '0) && !zero_s;
		end
	end

	// ---------------- restoring dividers, one quotient bit a stage ----------------
	for (genvar j = 1; j <= NW; j++) begin : g_div
		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [F:0] t;
			logic ge;

			assign t = {dv_rem_s[j-1][l], dv_num_s[j-1][l][NW-1]};
			assign ge = (t >= dv_div_s[j-1]);

			always_ff @(posedge clk) begin
				if (adv[NR+CS+1+j]) begin
					dv_rem_s[j][l] <= ge ? F'(t - dv_div_s[j-1]) : F'(t);
					dv_num_s[j][l] <= {dv_num_s[j-1][l][NW-2:0], ge};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv[NR+CS+1+j]) begin
				dv_neg_s[j] <= dv_neg_s[j-1];
				dv_div_s[j] <= dv_div_s[j-1];
				dv_code_s[j] <= dv_code_s[j-1];
				dv_ok_s[j] <= dv_ok_s[j-1];
			end
		end
	end

	// ---------------- sign and saturation of the quotients ----------------
	logic [FIELD_W-1:0] axis_o [0:2];

	for (genvar l = 0; l < 3; l++) begin : g_sat
		logic [NW-1:0] q;

		assign q = dv_num_s[NW][l];

		always_comb begin
			if (!dv_ok_s[NW]) begin
				axis_o[l] = '0;
			end else if (dv_neg_s[NW][2-l]) begin
				axis_o[l] = (q > NW'(32768)) ? AXIS_NEG_MAX : FIELD_W'(-q);
			end else begin
				axis_o[l] = (q > NW'(32767)) ? AXIS_POS_MAX : FIELD_W'(q);
			end
		end
	end

	assign axang.valid = vld_s[NT-1];
	assign axang.angle_deg = dv_code_s[NW];
	assign axang.axis_x = axis_o[0];
	assign axang.axis_y = axis_o[1];
	assign axang.axis_z = axis_o[2];
	assign axang.axis_valid = dv_ok_s[NW];

	// ---------------- checks ----------------
	`ASSERT_PROP(a_null_axis, clk, arst_n, axang.valid && !axang.axis_valid |-> axang.axis_x == 0 && axang.axis_y == 0 && axang.axis_z == 0)
	`ASSERT_NEVER(a_angle_range, clk, arst_n, axang.valid && axang.angle_deg >= FULL_TURN_CODE)
	`ASSERT_PROP(a_stall_full, clk, arst_n, !quat.ready |-> vld_s[NT-1] && !axang.ready)

endmodule
